@@ rtl/tlik_pkg.sv @@
// Shared widths, constants and the arctangent table for the two-link
// inverse kinematics core. No dependencies.
package tlik_pkg;

   localparam int XY_W      = 24;   // signed 16.8 coordinates
   localparam int LL_W      = 23;   // link length, unsigned 15.8
   localparam int GR_W      = 24;   // gear ratio, unsigned 8.16
   localparam int OFS_W     = 32;   // base offset, signed 5.27 radians
   localparam int R2_W      = 48;   // squared radius and squared reach
   localparam int SQN_W     = 62;   // square root radicand
   localparam int SQ_W      = 63;   // square root working width
   localparam int ROOT_W    = 31;   // square root result
   localparam int SQRT_STEPS = 31;  // one result bit per stage
   localparam int CW        = 36;   // CORDIC x/y width
   localparam int ZW        = 35;   // Q30 angle width
   localparam int ADEG_W    = 40;
   localparam int BDEG_W    = 24;

   localparam logic signed [ZW-1:0] PI_Q30    = 35'sd3373259426;
   localparam logic signed [20:0]   DEG_Q14   = 21'sd938734;
   localparam logic [BDEG_W-1:0]    ELBOW_MAX = 24'd11796480;

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

endpackage

@@ rtl/tlik_front.sv @@
// Front stages: squares of the target and the link, reach test and the
// square root radicands. Depends on tlik_pkg.
module tlik_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                valid_in,
   input  logic signed [tlik_pkg::XY_W-1:0]    x_in,
   input  logic signed [tlik_pkg::XY_W-1:0]    y_in,
   input  logic [tlik_pkg::LL_W-1:0]           link_length,
   output logic                                valid_out,
   output logic                                far_out,
   output logic signed [tlik_pkg::XY_W-1:0]    x_out,
   output logic signed [tlik_pkg::XY_W-1:0]    y_out,
   output logic [tlik_pkg::SQN_W-1:0]          nh_out,
   output logic [tlik_pkg::SQN_W-1:0]          nr_out
);

   logic [1:0]                          valid_ff;
   logic signed [47:0]                  xx_in, yy_in;
   logic [46:0]                         xx_ff, yy_ff;
   logic [45:0]                         ll_in, ll_ff;
   logic signed [tlik_pkg::XY_W-1:0]    xa_ff, ya_ff, xb_ff, yb_ff;
   logic [tlik_pkg::R2_W-1:0]           r2, reach2;
   logic                                far_in, far_ff;
   logic [tlik_pkg::SQN_W-1:0]          nh_in, nr_in, nh_ff, nr_ff;

   assign xx_in = x_in * x_in;
   assign yy_in = y_in * y_in;
   assign ll_in = link_length * link_length;

   assign r2     = tlik_pkg::R2_W'(xx_ff) + tlik_pkg::R2_W'(yy_ff);
   assign reach2 = {ll_ff, 2'b00};
   assign far_in = r2 > reach2;
   assign nh_in  = far_in ? '0 : (tlik_pkg::SQN_W'(reach2 - r2) << 14);
   assign nr_in  = tlik_pkg::SQN_W'(r2) << 14;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xx_ff  <= xx_in[46:0];
         yy_ff  <= yy_in[46:0];
         ll_ff  <= ll_in;
         xa_ff  <= x_in;
         ya_ff  <= y_in;
         xb_ff  <= xa_ff;
         yb_ff  <= ya_ff;
         far_ff <= far_in;
         nh_ff  <= nh_in;
         nr_ff  <= nr_in;
      end
   end

   assign valid_out = valid_ff[1];
   assign far_out   = far_ff;
   assign x_out     = xb_ff;
   assign y_out     = yb_ff;
   assign nh_out    = nh_ff;
   assign nr_out    = nr_ff;

endmodule

@@ rtl/tlik_isqrt_pipe.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on tlik_pkg.
module tlik_isqrt_pipe (
   input  logic                               clock,
   input  logic                               en,
   input  logic [tlik_pkg::SQN_W-1:0]         n_in,
   output logic [tlik_pkg::ROOT_W-1:0]        root_out
);

   localparam int N = tlik_pkg::SQRT_STEPS;

   logic [tlik_pkg::SQ_W-1:0] rem_ff [N];
   logic [tlik_pkg::SQ_W-1:0] res_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      localparam logic [tlik_pkg::SQ_W-1:0] BIT = tlik_pkg::SQ_W'(1) << (2 * (N - 1 - k));
      logic [tlik_pkg::SQ_W-1:0] rem_prev, res_prev, trial, rem_in, res_in;

      if (k == 0) begin : g_first
         assign rem_prev = tlik_pkg::SQ_W'(n_in);
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign res_prev = res_ff[k-1];
      end

      always_comb begin
         trial = res_prev + BIT;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) + BIT;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            res_ff[k] <= res_in;
         end
      end
   end

   assign root_out = res_ff[N-1][tlik_pkg::ROOT_W-1:0];

endmodule

@@ rtl/tlik_cordic_pipe.sv @@
// Pipelined vectoring CORDIC giving atan2(py, px) in Q30 radians,
// one rotation per stage. Depends on tlik_pkg.
module tlik_cordic_pipe #(
   parameter int STEPS = 24
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [tlik_pkg::CW-1:0]    px_in,
   input  logic signed [tlik_pkg::CW-1:0]    py_in,
   output logic signed [tlik_pkg::ZW-1:0]    z_out
);

   logic signed [tlik_pkg::CW-1:0] px0, py0;
   logic signed [tlik_pkg::ZW-1:0] z0;
   logic                           done0;

   logic signed [tlik_pkg::CW-1:0] px_ff [STEPS];
   logic signed [tlik_pkg::CW-1:0] py_ff [STEPS];
   logic signed [tlik_pkg::ZW-1:0] z_ff  [STEPS];
   logic                           done_ff [STEPS];

   // On the x axis the angle is fixed; left half-plane is folded over by pi.
   always_comb begin
      px0   = px_in;
      py0   = py_in;
      z0    = '0;
      done0 = 1'b0;
      if (py_in == '0) begin
         done0 = 1'b1;
         z0    = (px_in < 0) ? tlik_pkg::PI_Q30 : '0;
      end else if (px_in < 0) begin
         z0  = (py_in > 0) ? tlik_pkg::PI_Q30 : -tlik_pkg::PI_Q30;
         px0 = -px_in;
         py0 = -py_in;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_stage
      localparam logic signed [tlik_pkg::ZW-1:0] ANG = tlik_pkg::ZW'(tlik_pkg::ATAN_TAB[k]);
      logic signed [tlik_pkg::CW-1:0] px_prev, py_prev, px_in_k, py_in_k;
      logic signed [tlik_pkg::ZW-1:0] z_prev, z_in;
      logic                           done_prev;

      if (k == 0) begin : g_first
         assign px_prev   = px0;
         assign py_prev   = py0;
         assign z_prev    = z0;
         assign done_prev = done0;
      end else begin : g_next
         assign px_prev   = px_ff[k-1];
         assign py_prev   = py_ff[k-1];
         assign z_prev    = z_ff[k-1];
         assign done_prev = done_ff[k-1];
      end

      always_comb begin
         if (done_prev) begin
            px_in_k = px_prev;
            py_in_k = py_prev;
            z_in    = z_prev;
         end else if (py_prev > 0) begin
            px_in_k = px_prev + (py_prev >>> k);
            py_in_k = py_prev - (px_prev >>> k);
            z_in    = z_prev + ANG;
         end else begin
            px_in_k = px_prev - (py_prev >>> k);
            py_in_k = py_prev + (px_prev >>> k);
            z_in    = z_prev - ANG;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            px_ff[k]   <= px_in_k;
            py_ff[k]   <= py_in_k;
            z_ff[k]    <= z_in;
            done_ff[k] <= done_prev;
         end
      end
   end

   assign z_out = z_ff[STEPS-1];

endmodule

@@ rtl/tlik_angle_out.sv @@
// Back stages: base and elbow angles, gear scaling, offset, conversion to
// degrees and the output register. Depends on tlik_pkg.
module tlik_angle_out (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 valid_in,
   input  logic                                 far_in,
   input  logic signed [tlik_pkg::ZW-1:0]       theta_in,
   input  logic signed [tlik_pkg::ZW-1:0]       t_in,
   input  logic [tlik_pkg::GR_W-1:0]            gear_scale,
   input  logic signed [tlik_pkg::OFS_W-1:0]    base_offset,
   output logic                                 valid_out,
   output logic signed [tlik_pkg::ADEG_W-1:0]   angle_a_deg,
   output logic [tlik_pkg::BDEG_W-1:0]          angle_b_deg,
   output logic                                 out_of_reach
);

   localparam int CW = tlik_pkg::CW;

   logic [4:0]                     valid_ff;
   logic [4:0]                     far_ff;
   logic signed [tlik_pkg::ZW-1:0] t_eff;
   logic signed [CW-1:0]           sum_in, sum_ff, b_in, b_ff;
   logic signed [60:0]             gprod_in, gprod_ff;
   logic signed [56:0]             bprod_in, bprod_ff;
   logic signed [45:0]             aq_in, aq_ff;
   logic signed [28:0]             bd;
   logic [tlik_pkg::BDEG_W-1:0]    bdeg_in, bdeg3_ff, bdeg4_ff, bdeg5_ff;
   logic signed [66:0]             aprod_in, aprod_ff;
   logic signed [66:0]             around;
   logic signed [tlik_pkg::ADEG_W-1:0] adeg_ff;

   // Out of reach: acos argument saturates, so the half-angle is zero.
   assign t_eff  = far_in ? '0 : t_in;
   assign sum_in = CW'(theta_in) + CW'(t_eff);
   assign b_in   = CW'(tlik_pkg::PI_Q30) - (CW'(t_eff) <<< 1);

   assign gprod_in = sum_ff * $signed({1'b0, gear_scale});
   assign bprod_in = b_ff * tlik_pkg::DEG_Q14;

   assign aq_in = 46'((gprod_ff + 61'sd32768) >>> 16) - (46'(base_offset) <<< 3);
   assign bd    = 29'((bprod_ff + 57'sd134217728) >>> 28);

   always_comb begin
      if (bd < 0) begin
         bdeg_in = '0;
      end else if (bd > $signed({5'b0, tlik_pkg::ELBOW_MAX})) begin
         bdeg_in = tlik_pkg::ELBOW_MAX;
      end else begin
         bdeg_in = bd[tlik_pkg::BDEG_W-1:0];
      end
   end

   assign aprod_in = aq_ff * tlik_pkg::DEG_Q14;
   assign around   = (aprod_ff + 67'sd134217728) >>> 28;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         far_ff   <= {far_ff[3:0], far_in};
         sum_ff   <= sum_in;
         b_ff     <= b_in;
         gprod_ff <= gprod_in;
         bprod_ff <= bprod_in;
         aq_ff    <= aq_in;
         bdeg3_ff <= bdeg_in;
         aprod_ff <= aprod_in;
         bdeg4_ff <= bdeg3_ff;
         adeg_ff  <= around[tlik_pkg::ADEG_W-1:0];
         bdeg5_ff <= bdeg4_ff;
      end
   end

   assign valid_out    = valid_ff[4];
   assign angle_a_deg  = adeg_ff;
   assign angle_b_deg  = bdeg5_ff;
   assign out_of_reach = far_ff[4];

endmodule

@@ rtl/two_link_inverse_kinematics_core.sv @@
// Two-link (equal links) inverse kinematics: one target point in, one pair
// of motor angles in degrees out. Depends on tlik_pkg and all tlik_ modules.
//
// The core takes one point per clock while no result is held. Its
// stages are 2 front stages (squares, reach test), 31 square root
// stages, CORDIC_STEPS rotation stages for both arctangents in parallel,
// and 5 stages of gear scaling, degree conversion and output register.
// The whole pipe advances together: it holds while a result waits on
// rsp_tready and loses nothing. Configuration registers are read straight
// by the pipe, so write them only while no point is in flight.
module two_link_inverse_kinematics_core #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // x_pos [23:0], y_pos [47:24]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // angle_a_deg [39:0], angle_b_deg [63:40]
   output logic         rsp_tuser,   // out_of_reach
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int SQ = tlik_pkg::SQRT_STEPS;

   localparam logic [1:0] CSR_LINK_LENGTH = 2'd0;
   localparam logic [1:0] CSR_GEAR_SCALE  = 2'd1;
   localparam logic [1:0] CSR_BASE_OFFSET = 2'd2;

   logic [tlik_pkg::LL_W-1:0]          link_length_ff;
   logic [tlik_pkg::GR_W-1:0]          gear_scale_ff;
   logic signed [tlik_pkg::OFS_W-1:0]  base_offset_ff;
   logic                               csr_wr;

   logic                               en;
   logic                               f_valid, f_far;
   logic signed [tlik_pkg::XY_W-1:0]   f_x, f_y;
   logic [tlik_pkg::SQN_W-1:0]         f_nh, f_nr;
   logic [tlik_pkg::ROOT_W-1:0]        root_h, root_r;

   logic [SQ-1:0]                      sv_ff, sf_ff;
   logic signed [tlik_pkg::XY_W-1:0]   sx_ff [SQ];
   logic signed [tlik_pkg::XY_W-1:0]   sy_ff [SQ];
   logic [CORDIC_STEPS-1:0]            cv_ff, cf_ff;

   logic signed [tlik_pkg::CW-1:0]     th_px, th_py, t_px, t_py;
   logic signed [tlik_pkg::ZW-1:0]     theta, t_half;
   logic signed [tlik_pkg::ADEG_W-1:0] angle_a;
   logic [tlik_pkg::BDEG_W-1:0]        angle_b;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_length_ff <= tlik_pkg::LL_W'(25600);
         gear_scale_ff  <= tlik_pkg::GR_W'(65536);
         base_offset_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            CSR_LINK_LENGTH: link_length_ff <= csr_pwdata[tlik_pkg::LL_W-1:0];
            CSR_GEAR_SCALE:  gear_scale_ff  <= csr_pwdata[tlik_pkg::GR_W-1:0];
            CSR_BASE_OFFSET: base_offset_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_LINK_LENGTH: csr_prdata = 32'(link_length_ff);
         CSR_GEAR_SCALE:  csr_prdata = 32'(gear_scale_ff);
         CSR_BASE_OFFSET: csr_prdata = base_offset_ff;
         default:         csr_prdata = '0;
      endcase
   end

   // Whole pipe advances unless the output beat is held
   assign en         = ~rsp_tvalid | rsp_tready;
   assign req_tready = en;

   tlik_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .valid_in    (req_tvalid),
      .x_in        (req_tdata[23:0]),
      .y_in        (req_tdata[47:24]),
      .link_length (link_length_ff),
      .valid_out   (f_valid),
      .far_out     (f_far),
      .x_out       (f_x),
      .y_out       (f_y),
      .nh_out      (f_nh),
      .nr_out      (f_nr)
   );

   tlik_isqrt_pipe u_sqrt_h (
      .clock    (clock),
      .en       (en),
      .n_in     (f_nh),
      .root_out (root_h)
   );

   tlik_isqrt_pipe u_sqrt_r (
      .clock    (clock),
      .en       (en),
      .n_in     (f_nr),
      .root_out (root_r)
   );

   // Carry valid, reach flag and target alongside the square roots
   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= '0;
         cv_ff <= '0;
      end else if (en) begin
         sv_ff <= {sv_ff[SQ-2:0], f_valid};
         cv_ff <= {cv_ff[CORDIC_STEPS-2:0], sv_ff[SQ-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sf_ff    <= {sf_ff[SQ-2:0], f_far};
         cf_ff    <= {cf_ff[CORDIC_STEPS-2:0], sf_ff[SQ-1]};
         sx_ff[0] <= f_x;
         sy_ff[0] <= f_y;
         for (int i = 1; i < SQ; i++) begin
            sx_ff[i] <= sx_ff[i-1];
            sy_ff[i] <= sy_ff[i-1];
         end
      end
   end

   assign th_px = tlik_pkg::CW'(sx_ff[SQ-1]) <<< 7;
   assign th_py = tlik_pkg::CW'(sy_ff[SQ-1]) <<< 7;
   assign t_px  = $signed(tlik_pkg::CW'(root_r));
   assign t_py  = $signed(tlik_pkg::CW'(root_h));

   tlik_cordic_pipe #(.STEPS(CORDIC_STEPS)) u_cordic_theta (
      .clock (clock),
      .en    (en),
      .px_in (th_px),
      .py_in (th_py),
      .z_out (theta)
   );

   tlik_cordic_pipe #(.STEPS(CORDIC_STEPS)) u_cordic_t (
      .clock (clock),
      .en    (en),
      .px_in (t_px),
      .py_in (t_py),
      .z_out (t_half)
   );

   tlik_angle_out u_out (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .valid_in     (cv_ff[CORDIC_STEPS-1]),
      .far_in       (cf_ff[CORDIC_STEPS-1]),
      .theta_in     (theta),
      .t_in         (t_half),
      .gear_scale   (gear_scale_ff),
      .base_offset  (base_offset_ff),
      .valid_out    (rsp_tvalid),
      .angle_a_deg  (angle_a),
      .angle_b_deg  (angle_b),
      .out_of_reach (rsp_tuser)
   );

   assign rsp_tdata = {angle_b, angle_a};

endmodule

@@ test/testbench.sv @@
// Self-checking bench for two_link_inverse_kinematics_core: random and directed target
// points, predicted angles, field-by-field result checks. Depends on tlik_pkg and the core.
`timescale 1ns / 1ps

module testbench;

   localparam int STEPS = 24;
   localparam int REG_LINK = 0, REG_GEAR = 1, REG_OFFSET = 2;
   localparam longint PI_RAD = 64'sd3373259426;
   localparam longint ELBOW_TOP = 64'sd11796480;

   typedef struct packed {
      logic [tlik_pkg::ADEG_W-1:0] angle_a;
      logic [tlik_pkg::BDEG_W-1:0] angle_b;
      logic                        far;
   } angles_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // x_pos [23:0], y_pos [47:24]
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;        // angle_a_deg [39:0], angle_b_deg [63:40]
   logic        rsp_tuser;        // out_of_reach
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   two_link_inverse_kinematics_core #(.CORDIC_STEPS(STEPS)) dut (.*);

   always #10 clock = ~clock;

   // configuration as the core should see it
   longint link_len = 25600, gear = 65536, offset_rad = 0;

   logic [47:0] points_to_send[$];
   angles_type  angles_due[$];
   int          errors = 0;
   bit          send_idle = 0, recv_idle = 0;
   int          send_gap = 0, recv_stall = 0, hold_left = 0;
   bit          hold_req = 0, hold_seen = 0;

   task automatic report(input string what);
      $display("mismatch %0d: %s", errors, what);
      errors++;
   endtask

   function automatic longint root_of(longint unsigned n);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n -= res + bit_v;
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return longint'(res);
   endfunction

   // vectoring CORDIC, Q30 radians in (-pi, pi]
   function automatic longint angle_of(longint px, longint py);
      longint z, dx, dy;
      z = 0;
      if (py == 0) return (px < 0) ? PI_RAD : 0;
      if (px < 0) begin
         z = (py > 0) ? PI_RAD : -PI_RAD;
         px = -px;
         py = -py;
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = py >>> i;
         dy = px >>> i;
         if (py > 0) begin
            px += dx; py -= dy; z += longint'(tlik_pkg::ATAN_TAB[i]);
         end else begin
            px -= dx; py += dy; z -= longint'(tlik_pkg::ATAN_TAB[i]);
         end
      end
      return z;
   endfunction

   function automatic longint degrees_of(longint rad);
      return (rad * 938734 + (64'sd1 <<< 27)) >>> 28;
   endfunction

   function automatic angles_type solve_arm(logic [47:0] pt);
      longint x, y, r2, reach2, theta, t, b, a_rad, a_deg, b_deg;
      angles_type res;
      x = longint'($signed(pt[23:0]));
      y = longint'($signed(pt[47:24]));
      r2 = x * x + y * y;
      reach2 = 4 * link_len * link_len;
      theta = angle_of(x * 128, y * 128);
      t = 0;
      if (r2 <= reach2)
         t = angle_of(root_of((r2) << 14), root_of((reach2 - r2) << 14));
      b = PI_RAD - 2 * t;
      a_rad = (((theta + t) * gear + 32768) >>> 16) - offset_rad * 8;
      a_deg = degrees_of(a_rad);
      b_deg = degrees_of(b);
      if (b_deg < 0) b_deg = 0;
      if (b_deg > ELBOW_TOP) b_deg = ELBOW_TOP;
      res.angle_a = a_deg[tlik_pkg::ADEG_W-1:0];
      res.angle_b = b_deg[tlik_pkg::BDEG_W-1:0];
      res.far = r2 > reach2;
      return res;
   endfunction

   // sender: accept beat, predict, load next point after a drawn gap
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         if (req_tvalid && req_tready) angles_due.push_back(solve_arm(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 0;
            end else if (points_to_send.size() > 0) begin
               req_tdata <= points_to_send.pop_front();
               req_tvalid <= 1;
               send_gap <= send_idle ? $urandom_range(0, 19) : 0;
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // receiver: check beat, then stall for a drawn count or a long hold-off
   always @(posedge clock) begin
      angles_type got, want;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[39:0], rsp_tdata[63:40], rsp_tuser};
            if (angles_due.size() == 0) begin
               report("result beat with nothing expected");
            end else begin
               want = angles_due.pop_front();
               if (got.angle_a !== want.angle_a)
                  report($sformatf("angle_a got %h want %h", got.angle_a, want.angle_a));
               if (got.angle_b !== want.angle_b)
                  report($sformatf("angle_b got %h want %h", got.angle_b, want.angle_b));
               if (got.far !== want.far)
                  report($sformatf("out_of_reach got %b want %b", got.far, want.far));
            end
         end
         if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 300;
            rsp_tready <= 0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 0;
         end else if (rsp_tvalid && rsp_tready) begin
            int d;
            d = recv_idle ? $urandom_range(0, 19) : 0;
            recv_stall <= d;
            rsp_tready <= (d == 0);
         end else if (!rsp_tready) begin
            if (recv_stall > 0) recv_stall <= recv_stall - 1;
            rsp_tready <= (recv_stall <= 1);
         end
      end
   end

   task automatic csr_write(input int idx, input longint value);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= 4'(4 * idx); csr_pwdata <= value[31:0];
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         REG_LINK:   link_len = value & 64'h7FFFFF;
         REG_GEAR:   gear = value & 64'hFFFFFF;
         REG_OFFSET: offset_rad = longint'($signed(value[31:0]));
         default: ;
      endcase
   endtask

   function automatic logic [23:0] coord_within(longint lim);
      longint v;
      if (lim > 8388607) lim = 8388607;
      v = longint'($urandom_range(0, 32'(2 * lim))) - lim;
      return v[23:0];
   endfunction

   function automatic logic [47:0] random_point();
      int kind;
      longint reach;
      kind = $urandom_range(0, 9);
      reach = 2 * link_len;
      if (kind < 6) return {coord_within(reach * 7 / 10), coord_within(reach * 7 / 10)};
      if (kind < 8) return {coord_within(reach + reach / 4 + 2), coord_within(reach + 2)};
      if (kind < 9) return {24'($urandom), 24'($urandom)};
      return {coord_within(8), coord_within(8)};
   endfunction

   task automatic drain();
      wait (points_to_send.size() == 0 && !req_tvalid && angles_due.size() == 0);
      repeat (80) @(posedge clock);
   endtask

   longint phase_link[7] = '{25600, 1, 8388607, 0, 100000, 3000000, 25600};
   longint phase_gear[7] = '{65536, 1, 16777215, 0, 131072, 40000, 65536};
   longint phase_ofs[7] = '{0, -64'sd2147483648, 2147483647, 0, 123456789, -98765432, 7};

   initial begin
      logic [23:0] two_l;
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed points on the reset configuration
      two_l = 24'd51200;
      points_to_send.push_back({24'd0, 24'd0});
      points_to_send.push_back({24'd0, -24'sd1});
      points_to_send.push_back({24'd0, 24'h800000});
      points_to_send.push_back({24'd0, 24'h7FFFFF});
      points_to_send.push_back({24'h7FFFFF, 24'd0});
      points_to_send.push_back({24'h800000, 24'd0});
      points_to_send.push_back({24'h800000, 24'h800000});
      points_to_send.push_back({24'h7FFFFF, 24'h7FFFFF});
      points_to_send.push_back({24'h7FFFFF, 24'h800000});
      points_to_send.push_back({24'd0, two_l});
      points_to_send.push_back({two_l, 24'd0});
      points_to_send.push_back({24'd0, two_l + 24'd1});
      points_to_send.push_back({-two_l, 24'd0});
      points_to_send.push_back({24'd1, 24'd1});
      points_to_send.push_back({-24'sd1, -24'sd1});
      points_to_send.push_back({24'd30000, -24'sd20000});
      points_to_send.push_back({24'd36204, 24'd36204});
      points_to_send.push_back({24'd36205, 24'd36205});
      drain();

      for (int p = 0; p < 7; p++) begin
         if (p > 0) begin
            csr_write(REG_LINK, phase_link[p]);
            csr_write(REG_GEAR, phase_gear[p]);
            csr_write(REG_OFFSET, phase_ofs[p]);
         end
         send_idle = (p % 3) != 1;
         recv_idle = (p % 3) != 2;
         for (int i = 0; i < 165; i++) points_to_send.push_back(random_point());
         // zero link length: the origin is the only reachable point
         if (link_len == 0) points_to_send.push_back(48'd0);
         if (p == 2) begin
            wait (points_to_send.size() < 120);
            hold_req = ~hold_req;
         end
         drain();
      end

      if (angles_due.size() != 0) report("results still expected at end of run");
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/tlik_pkg.sv
rtl/tlik_front.sv
rtl/tlik_isqrt_pipe.sv
rtl/tlik_cordic_pipe.sv
rtl/tlik_angle_out.sv
rtl/two_link_inverse_kinematics_core.sv
test/testbench.sv
